// File: rtl/tcur_pkg.sv
package tcur_pkg;

    // Register map (index = byte address / 4)
    localparam logic [1:0] REG_TICKS_PER_UNIT = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd1;
    localparam logic [1:0] REG_TRIGGER_TICKS  = 2'd2;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int TPU_W      = 16;
    localparam int TIMEOUT_W  = 20;
    localparam int TRIG_W     = 10;
    localparam int PRESCALE_W = 17;
    localparam int DIST_W     = 8;
    localparam int NUM_CH     = 3;

    localparam int COUNT_BITS_DEF = 20;

    localparam logic [TPU_W-1:0]     TPU_RESET     = 16'd15;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd768000;
    localparam logic [TRIG_W-1:0]    TRIG_RESET    = 10'd10;
    localparam logic [DIST_W-1:0]    DIST_MAX      = 8'd255;

    // Channel codes
    localparam logic [1:0] CH_CENTER = 2'd0;
    localparam logic [1:0] CH_LEFT   = 2'd1;
    localparam logic [1:0] CH_RIGHT  = 2'd2;

endpackage

// File: rtl/three_channel_ultrasonic_ranger_top.sv
// Three-channel ultrasonic ranger. Each input item is one timer tick carrying the echo
// levels of the center, left and right sonars (bits 0, 1, 2). The block triggers each
// sonar in turn for trigger_ticks ticks (at least one), times the echo high pulse and
// reports floor(ticks / (2 * ticks_per_unit)), saturated at 255; an echo longer than
// timeout_ticks, or one that fills the COUNT_BITS tick counter, reports 255. A one-tick
// pause follows each round. Every tick yields exactly one result item with the trigger
// drive, a done flag with its channel, and the three latched distances (255 after reset).
// One item is taken per clock cycle unless the output register is stalled, and nothing
// else holds the input back; its result appears there in the next cycle. The user must
// write registers over the APB-style port while the block is idle; it is not enforced.
module three_channel_ultrasonic_ranger_top #(
    parameter int COUNT_BITS = tcur_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_echo_levels,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_trigger_lines,
    output logic                          o_measure_done,
    output logic [1:0]                    o_done_channel,
    output logic [tcur_pkg::DIST_W-1:0]   o_distance_center,
    output logic [tcur_pkg::DIST_W-1:0]   o_distance_left,
    output logic [tcur_pkg::DIST_W-1:0]   o_distance_right,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcur_pkg::ADDR_W-1:0]   paddr,
    input  logic [tcur_pkg::DATA_W-1:0]   pwdata,
    output logic [tcur_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CMP_W = (COUNT_BITS > tcur_pkg::TIMEOUT_W) ? COUNT_BITS
                                                              : tcur_pkg::TIMEOUT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        TRIG_CENTER = 3'd0,
        MEAS_CENTER = 3'd1,
        TRIG_LEFT   = 3'd2,
        MEAS_LEFT   = 3'd3,
        TRIG_RIGHT  = 3'd4,
        MEAS_RIGHT  = 3'd5,
        PAUSE       = 3'd6
    } t_scan;

    // Configuration registers
    logic [tcur_pkg::TPU_W-1:0]     r_tpu;
    logic [tcur_pkg::TIMEOUT_W-1:0] r_timeout;
    logic [tcur_pkg::TRIG_W-1:0]    r_trig_ticks;

    // Measurement state
    t_scan                            r_scan, n_scan;
    logic                             r_echo_high, n_echo_high;
    logic [tcur_pkg::TRIG_W-1:0]      r_pulse_cnt, n_pulse_cnt;
    logic [COUNT_BITS-1:0]            r_echo_cnt, n_echo_cnt;
    logic [tcur_pkg::PRESCALE_W-1:0]  r_prescale, n_prescale;
    logic [tcur_pkg::DIST_W-1:0]      r_run_dist, n_run_dist;
    logic [tcur_pkg::DIST_W-1:0]      r_lat [tcur_pkg::NUM_CH];
    logic [tcur_pkg::DIST_W-1:0]      n_lat [tcur_pkg::NUM_CH];

    // Result register
    logic                             r_out_valid;
    logic [2:0]                       r_trig_out, n_trig_out;
    logic                             r_done, n_done;
    logic [1:0]                       r_chan, n_chan;

    logic                             in_acc;
    logic                             cfg_wr;
    logic [1:0]                       cfg_idx;
    logic [1:0]                       ch;
    logic                             trig_phase;
    logic                             meas_phase;
    logic                             echo_bit;
    logic [tcur_pkg::TPU_W-1:0]       tpu_eff;
    logic [tcur_pkg::PRESCALE_W-1:0]  divisor;
    logic [tcur_pkg::TRIG_W-1:0]      pulse_inc;
    logic [COUNT_BITS-1:0]            echo_inc;
    logic [tcur_pkg::PRESCALE_W-1:0]  prescale_inc;
    logic                             timed_out;
    logic                             finish;
    logic [tcur_pkg::DIST_W-1:0]      result;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            tcur_pkg::REG_TICKS_PER_UNIT: prdata = {16'd0, r_tpu};
            tcur_pkg::REG_TIMEOUT_TICKS:  prdata = {12'd0, r_timeout};
            tcur_pkg::REG_TRIGGER_TICKS:  prdata = {22'd0, r_trig_ticks};
            default:                      prdata = '0;
        endcase
    end

    always_comb begin
        ch         = tcur_pkg::CH_CENTER;
        trig_phase = 1'b0;
        meas_phase = 1'b0;
        unique case (r_scan)
            TRIG_CENTER: begin ch = tcur_pkg::CH_CENTER; trig_phase = 1'b1; end
            MEAS_CENTER: begin ch = tcur_pkg::CH_CENTER; meas_phase = 1'b1; end
            TRIG_LEFT:   begin ch = tcur_pkg::CH_LEFT;   trig_phase = 1'b1; end
            MEAS_LEFT:   begin ch = tcur_pkg::CH_LEFT;   meas_phase = 1'b1; end
            TRIG_RIGHT:  begin ch = tcur_pkg::CH_RIGHT;  trig_phase = 1'b1; end
            MEAS_RIGHT:  begin ch = tcur_pkg::CH_RIGHT;  meas_phase = 1'b1; end
            default: begin end
        endcase
    end

    assign echo_bit     = i_echo_levels[ch];
    assign tpu_eff      = (r_tpu == '0) ? tcur_pkg::TPU_W'(1) : r_tpu;
    assign divisor      = {tpu_eff, 1'b0};
    assign pulse_inc    = r_pulse_cnt + 1'b1;
    assign echo_inc     = (r_echo_cnt == COUNT_LIMIT) ? r_echo_cnt : r_echo_cnt + 1'b1;
    assign prescale_inc = r_prescale + 1'b1;
    assign timed_out    = (CMP_W'(echo_inc) > CMP_W'(r_timeout)) || (echo_inc == COUNT_LIMIT);

    always_comb begin
        n_scan      = r_scan;
        n_echo_high = r_echo_high;
        n_pulse_cnt = r_pulse_cnt;
        n_echo_cnt  = r_echo_cnt;
        n_prescale  = r_prescale;
        n_run_dist  = r_run_dist;
        n_lat       = r_lat;
        n_trig_out  = 3'd0;
        n_done      = 1'b0;
        n_chan      = tcur_pkg::CH_CENTER;
        finish      = 1'b0;
        result      = r_run_dist;

        if (trig_phase) begin
            n_trig_out  = 3'd1 << ch;
            n_pulse_cnt = pulse_inc;
            if (pulse_inc >= r_trig_ticks) begin
                n_pulse_cnt = '0;
                n_echo_high = 1'b0;
                n_echo_cnt  = '0;
                n_prescale  = '0;
                n_run_dist  = '0;
                n_scan      = t_scan'(r_scan + 3'd1);
            end
        end else if (meas_phase) begin
            if (!r_echo_high) begin
                if (echo_bit) begin
                    n_echo_high = 1'b1;
                    n_echo_cnt  = '0;
                    n_prescale  = '0;
                    n_run_dist  = '0;
                end
            end else if (!echo_bit) begin
                // fall tick is not counted
                result = r_run_dist;
                finish = 1'b1;
            end else begin
                n_echo_cnt = echo_inc;
                n_prescale = prescale_inc;
                if (prescale_inc >= divisor) begin
                    n_prescale = '0;
                    if (r_run_dist != tcur_pkg::DIST_MAX) begin
                        n_run_dist = r_run_dist + 1'b1;
                    end
                end
                if (timed_out) begin
                    result = tcur_pkg::DIST_MAX;
                    finish = 1'b1;
                end
            end
            if (finish) begin
                n_lat[ch]   = result;
                n_done      = 1'b1;
                n_chan      = ch;
                n_echo_high = 1'b0;
                n_echo_cnt  = '0;
                n_prescale  = '0;
                n_run_dist  = '0;
                n_scan      = t_scan'(r_scan + 3'd1);
            end
        end else begin
            n_scan = TRIG_CENTER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu        <= tcur_pkg::TPU_RESET;
            r_timeout    <= tcur_pkg::TIMEOUT_RESET;
            r_trig_ticks <= tcur_pkg::TRIG_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                tcur_pkg::REG_TICKS_PER_UNIT: r_tpu <= pwdata[tcur_pkg::TPU_W-1:0];
                tcur_pkg::REG_TIMEOUT_TICKS:  r_timeout <= pwdata[tcur_pkg::TIMEOUT_W-1:0];
                tcur_pkg::REG_TRIGGER_TICKS:  r_trig_ticks <= pwdata[tcur_pkg::TRIG_W-1:0];
                default: begin end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= TRIG_CENTER;
            r_echo_high <= 1'b0;
            r_pulse_cnt <= '0;
            r_echo_cnt  <= '0;
            r_prescale  <= '0;
            r_run_dist  <= '0;
            for (int k = 0; k < tcur_pkg::NUM_CH; k++) begin
                r_lat[k] <= tcur_pkg::DIST_MAX;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_scan      <= n_scan;
                r_echo_high <= n_echo_high;
                r_pulse_cnt <= n_pulse_cnt;
                r_echo_cnt  <= n_echo_cnt;
                r_prescale  <= n_prescale;
                r_run_dist  <= n_run_dist;
                r_lat       <= n_lat;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_trig_out <= n_trig_out;
            r_done     <= n_done;
            r_chan     <= n_chan;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_trigger_lines   = r_trig_out;
    assign o_measure_done    = r_done;
    assign o_done_channel    = r_chan;
    assign o_distance_center = r_lat[0];
    assign o_distance_left   = r_lat[1];
    assign o_distance_right  = r_lat[2];

    a_trig_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_trigger_lines))
        else $error("more than one trigger line driven");

    a_no_trig_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_measure_done) |-> (o_trigger_lines == 3'd0))
        else $error("trigger driven on a measurement tick");

    a_idle_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_measure_done) |-> (o_done_channel == tcur_pkg::CH_CENTER))
        else $error("done_channel set without a measurement");

    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted item produced no result");

endmodule

// File: tb/sv/three_channel_ultrasonic_ranger_top_test.sv
`timescale 1ns / 100ps

module three_channel_ultrasonic_ranger_top_test;

    localparam logic [1:0]           REG_SPARE   = 2'd3;
    localparam logic [tcur_pkg::COUNT_BITS_DEF-1:0] COUNT_LIMIT = '1;
    localparam int                   QUIET_LIMIT = 2000;

    localparam logic [2:0] PH_TRIG_C = 3'd0;
    localparam logic [2:0] PH_MEAS_C = 3'd1;
    localparam logic [2:0] PH_TRIG_L = 3'd2;
    localparam logic [2:0] PH_MEAS_L = 3'd3;
    localparam logic [2:0] PH_TRIG_R = 3'd4;
    localparam logic [2:0] PH_MEAS_R = 3'd5;

    typedef struct packed {
        logic [2:0]                  trig;
        logic                        done;
        logic [1:0]                  chan;
        logic [tcur_pkg::DIST_W-1:0] d_center;
        logic [tcur_pkg::DIST_W-1:0] d_left;
        logic [tcur_pkg::DIST_W-1:0] d_right;
    } t_range_report;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [2:0]                    i_echo_levels = 3'd0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [2:0]                    o_trigger_lines;
    logic                          o_measure_done;
    logic [1:0]                    o_done_channel;
    logic [tcur_pkg::DIST_W-1:0]   o_distance_center;
    logic [tcur_pkg::DIST_W-1:0]   o_distance_left;
    logic [tcur_pkg::DIST_W-1:0]   o_distance_right;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [tcur_pkg::ADDR_W-1:0]   paddr = '0;
    logic [tcur_pkg::DATA_W-1:0]   pwdata = '0;
    logic [tcur_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    three_channel_ultrasonic_ranger_top i_dut (.*);

    always #6 i_clk = ~i_clk;

    // Ranger shadow: configuration and scan state
    logic [tcur_pkg::TPU_W-1:0]      cfg_tpu = tcur_pkg::TPU_RESET;
    logic [tcur_pkg::TIMEOUT_W-1:0]  cfg_timeout = tcur_pkg::TIMEOUT_RESET;
    logic [tcur_pkg::TRIG_W-1:0]     cfg_trig = tcur_pkg::TRIG_RESET;
    logic [2:0]                      scan = PH_TRIG_C;
    logic                            echo_up = 1'b0;
    logic [tcur_pkg::TRIG_W-1:0]     pulse_cnt = '0;
    logic [tcur_pkg::COUNT_BITS_DEF-1:0] echo_ticks = '0;
    logic [tcur_pkg::PRESCALE_W-1:0] prescale = '0;
    logic [tcur_pkg::DIST_W-1:0]     run_dist = '0;
    logic [tcur_pkg::DIST_W-1:0]     dist_latch [tcur_pkg::NUM_CH] =
        '{tcur_pkg::DIST_MAX, tcur_pkg::DIST_MAX, tcur_pkg::DIST_MAX};

    t_range_report ranges_due [$];
    logic [2:0]    echo_queue [$];
    logic [2:0]    echo_lvl = 3'd0;
    int            echo_run [tcur_pkg::NUM_CH] = '{0, 0, 0};
    int            feed_gap = 0;
    int            feed_burst = 0;
    int            hold_left = 0;
    int            hold_burst = 0;
    int            fail_count = 0;
    int            quiet = 0;

    logic [2:0] drill [18] = '{3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd0, 3'd7,
                               3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd0, 3'd4, 3'd0, 3'd5};

    function automatic t_range_report step_ranger(input logic [2:0] echo);
        t_range_report                   rep;
        logic [1:0]                      ch;
        logic                            finish;
        logic [tcur_pkg::DIST_W-1:0]     result;
        logic [tcur_pkg::PRESCALE_W-1:0] divisor;
        rep = '0;
        case (scan)
            PH_TRIG_C, PH_TRIG_L, PH_TRIG_R: begin
                rep.trig = 3'b001 << scan[2:1];
                pulse_cnt = pulse_cnt + 1'b1;
                if (pulse_cnt >= cfg_trig) begin
                    pulse_cnt = '0;
                    echo_up = 1'b0;
                    echo_ticks = '0;
                    prescale = '0;
                    run_dist = '0;
                    scan = scan + 3'd1;
                end
            end
            PH_MEAS_C, PH_MEAS_L, PH_MEAS_R: begin
                ch = scan[2:1];
                if (!echo_up) begin
                    if (echo[ch]) begin
                        echo_up = 1'b1;
                        echo_ticks = '0;
                        prescale = '0;
                        run_dist = '0;
                    end
                end else begin
                    finish = 1'b0;
                    result = '0;
                    // the fall tick ends the pulse without being counted
                    if (!echo[ch]) begin
                        result = run_dist;
                        finish = 1'b1;
                    end else begin
                        divisor = (cfg_tpu == '0) ? 17'd2 : {cfg_tpu, 1'b0};
                        if (echo_ticks < COUNT_LIMIT) echo_ticks = echo_ticks + 1'b1;
                        prescale = prescale + 1'b1;
                        if (prescale >= divisor) begin
                            prescale = '0;
                            if (run_dist != tcur_pkg::DIST_MAX) run_dist = run_dist + 1'b1;
                        end
                        if (echo_ticks > cfg_timeout || echo_ticks >= COUNT_LIMIT) begin
                            result = tcur_pkg::DIST_MAX;
                            finish = 1'b1;
                        end
                    end
                    if (finish) begin
                        dist_latch[ch] = result;
                        rep.done = 1'b1;
                        rep.chan = ch;
                        echo_up = 1'b0;
                        echo_ticks = '0;
                        prescale = '0;
                        run_dist = '0;
                        scan = scan + 3'd1;
                    end
                end
            end
            default: scan = PH_TRIG_C;
        endcase
        rep.d_center = dist_latch[tcur_pkg::CH_CENTER];
        rep.d_left = dist_latch[tcur_pkg::CH_LEFT];
        rep.d_right = dist_latch[tcur_pkg::CH_RIGHT];
        return rep;
    endfunction

    // Wait before the next item or result: random, with bursts of back-to-back traffic
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic int pulse_len();
        int unit2;
        int tmo;
        unit2 = 2 * ((cfg_tpu == '0) ? 1 : int'(cfg_tpu));
        tmo = int'(cfg_timeout);
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 3);
            1: return (unit2 * 4 < 400) ? $urandom_range(1, unit2 * 4) : $urandom_range(1, 400);
            2: return (tmo <= 800) ? $urandom_range((tmo < 3) ? 1 : tmo - 2, tmo + 4)
                                   : $urandom_range(1, 300);
            3: return (unit2 * 255 <= 1000) ? $urandom_range(unit2 * 255 - 2, unit2 * 255 + 20)
                                            : $urandom_range(1, 60);
            default: return $urandom_range(1, 120);
        endcase
    endfunction

    // Echo waveform: per channel, alternating high pulses and low gaps; random levels when noisy
    function automatic logic [2:0] next_echo(input bit noisy);
        int ch;
        if (noisy) return 3'($urandom_range(0, 7));
        for (ch = 0; ch < tcur_pkg::NUM_CH; ch++) begin
            if (echo_run[ch] == 0) begin
                echo_lvl[ch] = ~echo_lvl[ch];
                echo_run[ch] = echo_lvl[ch] ? pulse_len() : $urandom_range(1, 12);
            end
            echo_run[ch]--;
        end
        return echo_lvl;
    endfunction

    function automatic logic [31:0] pad_word(input logic [31:0] v, input int w);
        return ($urandom_range(0, 1) == 1) ? (v | ($urandom << w)) : v;
    endfunction

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] word);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            tcur_pkg::REG_TICKS_PER_UNIT: cfg_tpu = word[tcur_pkg::TPU_W-1:0];
            tcur_pkg::REG_TIMEOUT_TICKS:  cfg_timeout = word[tcur_pkg::TIMEOUT_W-1:0];
            tcur_pkg::REG_TRIGGER_TICKS:  cfg_trig = word[tcur_pkg::TRIG_W-1:0];
            default: ;
        endcase
    endtask

    // Wait for every item to be taken and every result checked, then let the block settle
    task automatic settle();
        while (echo_queue.size() != 0 || ranges_due.size() != 0 || i_in_valid)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            feed_gap <= 0;
        end else begin
            if (i_in_valid && !o_in_stall) ranges_due.push_back(step_ranger(i_echo_levels));
            if (!i_in_valid || !o_in_stall) begin
                if (feed_gap > 0) begin
                    i_in_valid <= 1'b0;
                    feed_gap <= feed_gap - 1;
                end else if (echo_queue.size() > 0) begin
                    i_echo_levels <= echo_queue.pop_front();
                    i_in_valid <= 1'b1;
                    feed_gap <= draw_wait(feed_burst);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin : monitor
        t_range_report got;
        t_range_report want;
        int            w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
        end else begin
            w = hold_left;
            if (o_out_valid && !i_out_stall) begin
                got = '{o_trigger_lines, o_measure_done, o_done_channel,
                        o_distance_center, o_distance_left, o_distance_right};
                if (ranges_due.size() == 0) begin
                    if (fail_count < 10) $display("%0t: result with nothing expected", $time);
                    fail_count++;
                end else begin
                    want = ranges_due.pop_front();
                    if (got.trig !== want.trig || got.done !== want.done ||
                        got.chan !== want.chan || got.d_center !== want.d_center ||
                        got.d_left !== want.d_left || got.d_right !== want.d_right) begin
                        if (fail_count < 10) begin
                            $write("%0t: mismatch, expected trig %b done %b chan %0d dist %0d/%0d/%0d, ",
                                   $time, want.trig, want.done, want.chan,
                                   want.d_center, want.d_left, want.d_right);
                            $display("got trig %b done %b chan %0d dist %0d/%0d/%0d",
                                     got.trig, got.done, got.chan,
                                     got.d_center, got.d_left, got.d_right);
                        end
                        fail_count++;
                    end
                end
                w = draw_wait(hold_burst);
            end
            if (w > 0) begin
                i_out_stall <= 1'b1;
                hold_left <= w - 1;
            end else begin
                i_out_stall <= 1'b0;
                hold_left <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet <= 0;
        else quiet <= quiet + 1;
    end

    initial begin
        wait (quiet >= QUIET_LIMIT);
        $display("** three_channel_ultrasonic_ranger_top: FAILED **");
        $finish;
    end

    initial begin
        int          phase_no;
        int          n;
        int          k;
        int          rand_items;
        bit          noisy;
        logic [15:0] tpu;
        logic [19:0] tmo;
        logic [9:0]  trg;
        rand_items = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A few ticks on reset settings, still inside the first trigger pulse
        repeat (5) echo_queue.push_back(3'($urandom_range(0, 7)));
        settle();

        // One-tick trigger, unit of one, short timeout: exact fall, timeout and zero distance
        set_reg(tcur_pkg::REG_TRIGGER_TICKS, 32'd0);
        set_reg(tcur_pkg::REG_TICKS_PER_UNIT, 32'd0);
        set_reg(tcur_pkg::REG_TIMEOUT_TICKS, 32'd3);
        set_reg(REG_SPARE, 32'hFFFF_FFFF);
        foreach (drill[i]) echo_queue.push_back(drill[i]);
        settle();

        phase_no = 0;
        while (rand_items < 1350) begin
            case (phase_no)
                0: begin
                    tpu = 16'd1;
                    tmo = 20'hFFFFF;
                    trg = 10'd1;
                end
                1: begin
                    tpu = 16'hFFFF;
                    tmo = 20'd1;
                    trg = 10'h3FF;
                end
                2: begin
                    tpu = 16'd1;
                    tmo = 20'd600;
                    trg = 10'd2;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: tpu = 16'd0;
                        1: tpu = 16'($urandom_range(1, 4));
                        2: tpu = 16'($urandom_range(5, 300));
                        default: tpu = 16'($urandom_range(1, 65535));
                    endcase
                    case ($urandom_range(0, 3))
                        0: tmo = 20'($urandom_range(1, 30));
                        1: tmo = 20'($urandom_range(31, 700));
                        2: tmo = 20'hFFFFF;
                        default: tmo = 20'($urandom_range(1, 1048575));
                    endcase
                    case ($urandom_range(0, 3))
                        0: trg = 10'd0;
                        1: trg = 10'd1;
                        default: trg = 10'($urandom_range(2, 24));
                    endcase
                end
            endcase
            set_reg(tcur_pkg::REG_TICKS_PER_UNIT, pad_word({16'd0, tpu}, tcur_pkg::TPU_W));
            set_reg(tcur_pkg::REG_TIMEOUT_TICKS, pad_word({12'd0, tmo}, tcur_pkg::TIMEOUT_W));
            set_reg(tcur_pkg::REG_TRIGGER_TICKS, pad_word({22'd0, trg}, tcur_pkg::TRIG_W));
            if ($urandom_range(0, 7) == 0) set_reg(REG_SPARE, $urandom);

            noisy = (phase_no > 2) && ($urandom_range(0, 9) == 0);
            n = (phase_no == 1) ? 1150 : $urandom_range(120, 260) + 3 * int'(cfg_trig);
            for (k = 0; k < n; k++) echo_queue.push_back(next_echo(noisy));
            rand_items += n;
            settle();
            phase_no++;
        end

        if (fail_count == 0) begin
            $display("** three_channel_ultrasonic_ranger_top: PASSED **");
        end else begin
            $display("** three_channel_ultrasonic_ranger_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/tcur_pkg.sv
rtl/three_channel_ultrasonic_ranger_top.sv
tb/sv/three_channel_ultrasonic_ranger_top_test.sv
